/* design/ttyld_pkg.sv */
// Shared types, constants and codes of the tty line discipline.
package ttyld_pkg;

    localparam int NUM_LAYERS = 8;
    localparam int LINE_DEPTH = 32;

    localparam int LAYER_W   = 3;
    localparam int CHAR_W    = 8;
    localparam int KIND_W    = 3;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 3;
    localparam int IDX_W     = $clog2(LINE_DEPTH);
    localparam int LEN_W     = $clog2(LINE_DEPTH + 1);
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_ECHO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CBREAK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRMOD  = 3'd3;

    localparam logic [KIND_W-1:0] KIND_ECHO = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PASS = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LINE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EOF  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INTR = 3'd4;
    localparam logic [KIND_W-1:0] KIND_QUIT = 3'd5;

    localparam logic [OP_W-1:0] OP_EOF   = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE = 3'd1;
    localparam logic [OP_W-1:0] OP_KILL  = 3'd2;
    localparam logic [OP_W-1:0] OP_INTR  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUIT  = 3'd4;
    localparam logic [OP_W-1:0] OP_ORD   = 3'd5;

    localparam logic [CHAR_W-1:0] CH_EOT   = 8'h04;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_FS    = 8'h1C;
    localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_MASK7 = 8'h7F;

    typedef struct packed {
        logic [LAYER_W-1:0] layer_index;
        logic [CHAR_W-1:0]  char_in;
    } in_req_t;

    typedef struct packed {
        logic [LAYER_W-1:0] target_layer;
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  data;
        logic               last;
    } out_req_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LAYER_W-1:0] layer;
        logic [CHAR_W-1:0]  ch;
        logic               echo;
        logic               rawmode;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

/* design/ttyld_front.sv */
// Front end: mode registers, character classification and command push.
module ttyld_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  ttyld_pkg::in_req_t           in_data,
    input  logic                         cfg_we,
    input  logic [ttyld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttyld_pkg::CHAR_W-1:0] cfg_data,
    input  ttyld_pkg::q_flags_t          q_flags,
    output logic                         q_push,
    output ttyld_pkg::cmd_t              q_cmd
);
    import ttyld_pkg::*;

    logic [7:0] echo_reg;
    logic [7:0] raw_reg;
    logic [7:0] cbreak_reg;
    logic [7:0] crmod_reg;

    logic [LAYER_W-1:0] lay;
    logic               raw;
    logic               rawmode;
    logic               crmod;
    logic [CHAR_W-1:0]  c;
    logic               in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg   <= '0;
            raw_reg    <= '0;
            cbreak_reg <= '0;
            crmod_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ECHO:   echo_reg   <= cfg_data;
                CFG_RAW:    raw_reg    <= cfg_data;
                CFG_CBREAK: cbreak_reg <= cfg_data;
                CFG_CRMOD:  crmod_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign in_stall = q_flags.full;
    assign lay      = in_data.layer_index;
    assign raw      = raw_reg[lay];
    assign rawmode  = raw | cbreak_reg[lay];
    assign crmod    = crmod_reg[lay];
    assign c        = raw ? in_data.char_in : (in_data.char_in & CH_MASK7);
    assign in_range = {1'b0, lay} < (LAYER_W + 1)'(NUM_LAYERS);
    assign q_push   = in_valid && !in_stall && in_range;

    always_comb
    begin
        q_cmd.layer   = lay;
        q_cmd.echo    = echo_reg[lay];
        q_cmd.rawmode = rawmode;
        q_cmd.ch      = c;
        if (!rawmode && c == CH_EOT)
            q_cmd.op = OP_EOF;
        else if (!rawmode && c == CH_BS)
            q_cmd.op = OP_ERASE;
        else if (!rawmode && c == CH_AT)
            q_cmd.op = OP_KILL;
        else if (!raw && c == CH_DEL)
            q_cmd.op = OP_INTR;
        else if (!raw && c == CH_FS)
            q_cmd.op = OP_QUIT;
        else
        begin
            q_cmd.op = OP_ORD;
            if (c == CH_CR && !rawmode && crmod)
                q_cmd.ch = CH_LF;
        end
    end

endmodule

/* design/ttyld_fifo.sv */
// Short command queue between front end and back end.
module ttyld_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ttyld_pkg::cmd_t     push_cmd,
    input  logic                pop,
    output ttyld_pkg::cmd_t     pop_cmd,
    output ttyld_pkg::q_flags_t flags
);
    import ttyld_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign flags.full  = count_reg == (QPTR_W + 1)'(QDEPTH);
    assign flags.empty = count_reg == '0;
    assign pop_cmd     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_W + 1)'(1);
        end
    end

endmodule

/* design/ttyld_back.sv */
// Back end: line buffers, line lengths and result sequencing.
module ttyld_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ttyld_pkg::q_flags_t q_flags,
    input  ttyld_pkg::cmd_t     q_cmd,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output ttyld_pkg::out_req_t out_data
);
    import ttyld_pkg::*;

    localparam int MEM_AW    = LAYER_W + IDX_W;
    localparam int MEM_DEPTH = 2 ** MEM_AW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_ECHO1 = 3'd2;
    localparam logic [2:0] S_ECHO2 = 3'd3;
    localparam logic [2:0] S_SIG   = 3'd4;
    localparam logic [2:0] S_PASS  = 3'd5;
    localparam logic [2:0] S_STORE = 3'd6;
    localparam logic [2:0] S_LREAD = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic              lout_reg, lout_next;
    cmd_t              cmd_reg, cmd_next;
    logic [LEN_W-1:0]  len_reg [2 ** LAYER_W];
    logic [LEN_W-1:0]  total_reg, total_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    out_req_t          out_data_reg, out_data_next;
    logic [CHAR_W-1:0] mem [MEM_DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    logic              out_free;
    logic              len_we;
    logic [LEN_W-1:0]  len_wval;
    logic [LEN_W-1:0]  len_cur;
    logic [LEN_W-1:0]  len_grown;
    logic [LEN_W-1:0]  idx_inc;
    logic              mem_we;
    logic              mem_re;
    logic              line_end;
    logic [KIND_W-1:0] sig_kind;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign len_cur   = len_reg[cmd_reg.layer];
    assign idx_inc   = idx_reg + LEN_W'(1);
    assign line_end  = idx_inc == total_reg;
    assign len_grown = (len_cur < LEN_W'(LINE_DEPTH)) ? len_cur + LEN_W'(1) : len_cur;
    assign q_pop     = state_reg == S_IDLE && !lout_reg && !q_flags.empty;

    always_comb
    begin
        case (cmd_reg.op)
            OP_EOF:  sig_kind = KIND_EOF;
            OP_INTR: sig_kind = KIND_INTR;
            default: sig_kind = KIND_QUIT;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        lout_next      = lout_reg;
        cmd_next       = cmd_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        len_we         = 1'b0;
        len_wval       = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (lout_reg)
        begin
            // registered line character is ready to go out
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{cmd_reg.layer, KIND_LINE, rdata_reg, line_end};
                idx_next       = idx_inc;
                lout_next      = 1'b0;
                state_next     = line_end ? S_IDLE : S_LREAD;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        cmd_next   = q_cmd;
                        state_next = S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    case (cmd_reg.op)
                        OP_EOF:
                            state_next = S_SIG;
                        OP_INTR, OP_QUIT:
                        begin
                            len_we     = 1'b1;
                            state_next = S_SIG;
                        end
                        OP_ERASE:
                        begin
                            len_we     = 1'b1;
                            len_wval   = (len_cur != '0) ? len_cur - LEN_W'(1) : len_cur;
                            state_next = cmd_reg.echo ? S_ECHO1 : S_IDLE;
                        end
                        OP_KILL:
                        begin
                            len_we     = 1'b1;
                            state_next = cmd_reg.echo ? S_ECHO1 : S_IDLE;
                        end
                        OP_ORD:
                        begin
                            if (cmd_reg.echo)
                                state_next = S_ECHO1;
                            else if (cmd_reg.rawmode)
                                state_next = S_PASS;
                            else
                                state_next = S_STORE;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
                S_ECHO1:
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next.target_layer = cmd_reg.layer;
                        out_data_next.kind         = KIND_ECHO;
                        out_data_next.data = (cmd_reg.op == OP_KILL) ? CH_AT : cmd_reg.ch;
                        out_data_next.last = (cmd_reg.op == OP_ERASE)
                            || (cmd_reg.op == OP_ORD && !cmd_reg.rawmode
                                && cmd_reg.ch != CH_LF);
                        if (cmd_reg.op == OP_KILL)
                            state_next = S_ECHO2;
                        else if (cmd_reg.op == OP_ERASE)
                            state_next = S_IDLE;
                        else if (cmd_reg.rawmode)
                            state_next = S_PASS;
                        else
                            state_next = S_STORE;
                    end
                end
                S_ECHO2:
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{cmd_reg.layer, KIND_ECHO, CH_LF, 1'b1};
                        state_next     = S_IDLE;
                    end
                end
                S_SIG:
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{cmd_reg.layer, sig_kind, '0, 1'b1};
                        state_next     = S_IDLE;
                    end
                end
                S_PASS:
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{cmd_reg.layer, KIND_PASS, cmd_reg.ch, 1'b1};
                        state_next     = S_IDLE;
                    end
                end
                S_STORE:
                begin
                    mem_we = len_cur < LEN_W'(LINE_DEPTH);
                    len_we = 1'b1;
                    if (cmd_reg.ch == CH_LF)
                    begin
                        total_next = len_grown;
                        idx_next   = '0;
                        state_next = S_LREAD;
                    end
                    else
                    begin
                        len_wval   = len_grown;
                        state_next = S_IDLE;
                    end
                end
                S_LREAD:
                begin
                    mem_re    = 1'b1;
                    lout_next = 1'b1;
                end
                default:
                    state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[{cmd_reg.layer, len_cur[IDX_W-1:0]}] <= cmd_reg.ch;
        if (mem_re)
            rdata_reg <= mem[{cmd_reg.layer, idx_reg[IDX_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        total_reg    <= total_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lout_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2 ** LAYER_W; i++)
                len_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lout_reg      <= lout_next;
            out_valid_reg <= out_valid_next;
            if (len_we)
                len_reg[cmd_reg.layer] <= len_wval;
        end
    end

endmodule

/* design/tty_line_discipline.sv */
// Top level of the tty line discipline: front end, command queue, back end.
//
//  channel   direction  handshake            payload
//  in        request in in_valid / in_stall  in_data   (layer_index, char_in)
//  out       result out out_valid / out_stall out_data (target_layer, kind, data, last)
//  cfg       write in   cfg_we               cfg_index, cfg_data
//
// Editing, signal and cooked characters are sequenced by the back end state machine;
// a completed line is sent out one buffered character at a time, each read through
// the registered read port of the line store.
// Reset clears the mode registers, the queue and every line length; no clearing pass.
// The queue holds 4 requests; in_stall rises only when it is full.
module tty_line_discipline (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ttyld_pkg::in_req_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ttyld_pkg::out_req_t             out_data,
    input  logic                            cfg_we,
    input  logic [ttyld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttyld_pkg::CHAR_W-1:0]    cfg_data
);
    import ttyld_pkg::*;

    q_flags_t q_flags;
    logic     q_push;
    logic     q_pop;
    cmd_t     push_cmd;
    cmd_t     pop_cmd;

    ttyld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_flags   (q_flags),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    ttyld_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .flags    (q_flags)
    );

    ttyld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_flags   (q_flags),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_flags.full))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_flags.empty)
        else $error("command queue underflow");

    a_signal_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_EOF || out_data.kind == KIND_INTR
            || out_data.kind == KIND_QUIT) |-> out_data.last && out_data.data == '0)
        else $error("signal result not single or has data");
`endif

endmodule
